>>> design/psrb_pkg.sv
// shared types and constants for the pump staging runtime balancer
// no dependencies
package psrb_pkg;

  localparam int NPUMPS = 3;
  localparam int IDX_W = 2;
  localparam int STAMP_W = 32;
  localparam int TEMP_W = 16;
  localparam int HYST_W = 12;
  localparam int CFG_W = 32;
  localparam int CMP_W = TEMP_W + 2;

  localparam logic [HYST_W-1:0] HYST_RESET = HYST_W'(80);
  localparam logic [STAMP_W-1:0] INTERVAL_RESET = STAMP_W'(30 * 60 * 1000);
  localparam logic [STAMP_W-1:0] MIN_OFF_RESET = STAMP_W'(15 * 60 * 1000);

  typedef logic [NPUMPS-1:0][STAMP_W-1:0] stamp_arr_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_ON   = 2'd1,
    ACT_OFF  = 2'd2,
    ACT_RSVD = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_REGULATE = 2'd0,
    MODE_FORCE    = 2'd1,
    MODE_SHUTDOWN = 2'd2,
    MODE_NOP      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_HYST     = 2'd0,
    CFG_INTERVAL = 2'd1,
    CFG_MIN_OFF  = 2'd2,
    CFG_NONE     = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic             stop_ok;
    logic [IDX_W-1:0] stop_idx;
    logic             start_ok;
    logic [IDX_W-1:0] start_idx;
  } sel_t;

endpackage

>>> design/psrb_select.sv
// candidate selection: running pump with most runtime, rested idle pump with least
// depends on psrb_pkg
module psrb_select import psrb_pkg::*; (
  input  logic [NPUMPS-1:0]  running,
  input  stamp_arr_t         runtime,
  input  stamp_arr_t         last_off,
  input  logic [STAMP_W-1:0] now_ms,
  input  logic [STAMP_W-1:0] min_off_ms,
  output sel_t               sel
);

  logic [NPUMPS-1:0] rested;

  always_comb begin
    for (int i = 0; i < NPUMPS; i++) begin
      rested[i] = (now_ms - last_off[i]) >= min_off_ms;
    end
  end

  // ties keep the lowest index
  always_comb begin
    sel = '0;
    for (int i = 0; i < NPUMPS; i++) begin
      if (running[i] && (!sel.stop_ok || runtime[i] > runtime[sel.stop_idx])) begin
        sel.stop_ok  = 1'b1;
        sel.stop_idx = IDX_W'(i);
      end
      if (!running[i] && rested[i] &&
          (!sel.start_ok || runtime[i] < runtime[sel.start_idx])) begin
        sel.start_ok  = 1'b1;
        sel.start_idx = IDX_W'(i);
      end
    end
  end

endmodule

>>> design/pump_staging_runtime_balancer_core.sv
// top level of the pump staging runtime balancer
// depends on psrb_pkg and psrb_select
//
// Usage:
//   in_*  : one item per sample (mode, pump index, timestamp, temperatures,
//           heating flag, optional runtime reports); accepted when in_valid
//           is high and in_stall is low
//   out_* : one result per item (pump mask, action, acted pump); taken when
//           out_valid is high and out_stall is low
//   cfg_* : register writes, taken on any cycle with cfg_we high
// The item is held in the input register; its result loads into the result
// register once that register is free, and can be taken from there.
// Throughput: one item per cycle while out_stall is low; the whole decision
// for an item is made combinationally, input register to result register.
// Reset (rst_n low, synchronous) stops every pump, clears runtimes and
// stamps, and restores the register defaults.
// When out_stall holds a result, one further item waits in the input
// register and in_stall rises until the result is taken.
module pump_staging_runtime_balancer_core import psrb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_mode,
  input  logic [1:0]               in_pump_index,
  input  logic [STAMP_W-1:0]       in_now_ms,
  input  logic signed [TEMP_W-1:0] in_current_temp,
  input  logic signed [TEMP_W-1:0] in_target_temp,
  input  logic                     in_heating,
  input  logic                     in_runtimes_present,
  input  logic [STAMP_W-1:0]       in_runtime_a,
  input  logic [STAMP_W-1:0]       in_runtime_b,
  input  logic [STAMP_W-1:0]       in_runtime_c,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [NPUMPS-1:0]        out_pump_on_mask,
  output logic [1:0]               out_action,
  output logic [1:0]               out_acted_pump
);

  logic [HYST_W-1:0]  hyst_r;
  logic [STAMP_W-1:0] interval_r;
  logic [STAMP_W-1:0] min_off_r;

  logic                     s1_valid_r;
  mode_t                    s1_mode_r;
  logic [IDX_W-1:0]         s1_pidx_r;
  logic [STAMP_W-1:0]       s1_now_r;
  logic signed [TEMP_W-1:0] s1_cur_r;
  logic signed [TEMP_W-1:0] s1_tgt_r;
  logic                     s1_heat_r;
  logic                     s1_fresh_r;
  stamp_arr_t               s1_rt_r;

  logic [NPUMPS-1:0]  run_r, run_nxt;
  stamp_arr_t         rt_r, rt_nxt;
  stamp_arr_t         off_r, off_nxt;
  logic [STAMP_W-1:0] chg_r, chg_nxt;

  logic              out_valid_r;
  logic [NPUMPS-1:0] out_mask_r;
  action_t           out_act_r, act_nxt;
  logic [IDX_W-1:0]  out_who_r, who_nxt;

  logic                    adv;
  logic                    in_take;
  logic                    interval_ok;
  logic signed [CMP_W-1:0] cur_x, tgt_x, hyst_x;
  logic                    temp_high, temp_low, stop_cond, start_cond;
  sel_t                    sel;

  assign adv     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  assign out_valid        = out_valid_r;
  assign out_pump_on_mask = out_mask_r;
  assign out_action       = out_act_r;
  assign out_acted_pump   = out_who_r;

  // runtime refresh ahead of the decision
  always_comb begin
    for (int i = 0; i < NPUMPS; i++) begin
      if (s1_fresh_r && s1_rt_r[i] != '0 && s1_rt_r[i] != '1) begin
        rt_nxt[i] = s1_rt_r[i];
      end else begin
        rt_nxt[i] = rt_r[i];
      end
    end
  end

  psrb_select u_select (
    .running    (run_r),
    .runtime    (rt_nxt),
    .last_off   (off_r),
    .now_ms     (s1_now_r),
    .min_off_ms (min_off_r),
    .sel        (sel)
  );

  assign interval_ok = (s1_now_r - chg_r) >= interval_r;
  assign cur_x       = CMP_W'(s1_cur_r);
  assign tgt_x       = CMP_W'(s1_tgt_r);
  assign hyst_x      = signed'(CMP_W'(hyst_r));
  assign temp_high   = cur_x >= tgt_x + hyst_x;
  assign temp_low    = cur_x <= tgt_x - hyst_x;
  assign stop_cond   = s1_heat_r ? temp_high : temp_low;
  assign start_cond  = s1_heat_r ? temp_low : temp_high;

  always_comb begin
    run_nxt = run_r;
    off_nxt = off_r;
    chg_nxt = chg_r;
    act_nxt = ACT_NONE;
    who_nxt = '0;
    case (s1_mode_r)
      MODE_REGULATE: begin
        if (interval_ok) begin
          if (stop_cond) begin
            if (sel.stop_ok) begin
              for (int i = 0; i < NPUMPS; i++) begin
                if (sel.stop_idx == IDX_W'(i)) begin
                  run_nxt[i] = 1'b0;
                  off_nxt[i] = s1_now_r;
                end
              end
              chg_nxt = s1_now_r;
              act_nxt = ACT_OFF;
              who_nxt = sel.stop_idx;
            end
          end else if (start_cond && sel.start_ok) begin
            for (int i = 0; i < NPUMPS; i++) begin
              if (sel.start_idx == IDX_W'(i)) begin
                run_nxt[i] = 1'b1;
              end
            end
            chg_nxt = s1_now_r;
            act_nxt = ACT_ON;
            who_nxt = sel.start_idx;
          end
        end
      end
      MODE_FORCE: begin
        for (int i = 0; i < NPUMPS; i++) begin
          if (s1_pidx_r == IDX_W'(i)) begin
            run_nxt[i] = 1'b0;
          end
        end
      end
      MODE_SHUTDOWN: begin
        run_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hyst_r     <= HYST_RESET;
      interval_r <= INTERVAL_RESET;
      min_off_r  <= MIN_OFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_HYST:     hyst_r     <= cfg_wdata[HYST_W-1:0];
        CFG_INTERVAL: interval_r <= cfg_wdata;
        CFG_MIN_OFF:  min_off_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r  <= mode_t'(in_mode);
      s1_pidx_r  <= in_pump_index;
      s1_now_r   <= in_now_ms;
      s1_cur_r   <= in_current_temp;
      s1_tgt_r   <= in_target_temp;
      s1_heat_r  <= in_heating;
      s1_fresh_r <= in_runtimes_present;
      s1_rt_r[0] <= in_runtime_a;
      s1_rt_r[1] <= in_runtime_b;
      s1_rt_r[2] <= in_runtime_c;
    end
  end

  // pump state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= '0;
      rt_r        <= '0;
      off_r       <= '0;
      chg_r       <= '0;
      out_valid_r <= 1'b0;
      out_mask_r  <= '0;
      out_act_r   <= ACT_NONE;
      out_who_r   <= '0;
    end else begin
      if (adv) begin
        run_r       <= run_nxt;
        rt_r        <= rt_nxt;
        off_r       <= off_nxt;
        chg_r       <= chg_nxt;
        out_valid_r <= 1'b1;
        out_mask_r  <= run_nxt;
        out_act_r   <= act_nxt;
        out_who_r   <= who_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_on_bit_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_ON |->
      ((out_pump_on_mask >> out_acted_pump) & 3'b001) != 3'b000)
    else $error("switched-on pump not shown running");

  a_off_bit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_OFF |->
      ((out_pump_on_mask >> out_acted_pump) & 3'b001) == 3'b000)
    else $error("switched-off pump still shown running");

  a_idle_no_pump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_NONE |-> out_acted_pump == '0)
    else $error("acted pump set without an action");

  a_change_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    adv && act_nxt != ACT_NONE |=> chg_r == $past(s1_now_r))
    else $error("change stamp not taken on a switch");

  a_one_change: assert property (@(posedge clk) disable iff (!rst_n)
    adv && act_nxt != ACT_NONE |-> $countones(run_nxt ^ run_r) == 1)
    else $error("switch did not change exactly one pump");
`endif

endmodule
